>>> src/dq_pkg.sv
package dq_pkg;

  // Fixed widths of the result fields.
  localparam int COUNT_W = 11;
  localparam int TASK_W  = 64;

  // Depth of the result queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = 2;
  localparam int Q_CNT_W = 3;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_STEAL = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Everything about one result that the front already knows.
  typedef struct packed {
    logic               got;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } meta_t;

endpackage

>>> src/work_stealing_deque.sv
// Results are registered at the transfer and queued until the result side takes them.
// Throughput: one command per cycle while in_ready is high; each successful push, pop
// or steal touches one slot of the single-port write, single-port read slot memory
// and moves one pointer.
// Reset: synchronous, active high; clears both pointers, the count and the result queue.
// The slot memory is not cleared, as only occupied slots are ever read.
module work_stealing_deque #(
  parameter int CAPACITY = 1024,
  parameter int HANDLE_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [dq_pkg::TASK_W-1:0]  task_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dq_pkg::TASK_W-1:0]  task_out,
  output logic                       got_task,
  output logic [1:0]                 status,
  output logic [dq_pkg::COUNT_W-1:0] count,
  output logic                       is_empty
);

  import dq_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);

  // The front owns the top and bottom pointers and the item count. It decides each
  // command's outcome in the cycle of its transfer, so a following command already
  // sees the updated pointers and no forwarding of pointer state is needed.
  logic                    in_fire;
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [HANDLE_WIDTH-1:0] ram_wdata;
  logic                    ram_re;
  logic [SLOT_W-1:0]       ram_raddr;
  logic [HANDLE_WIDTH-1:0] ram_rdata;
  logic                    s1_valid;
  meta_t                   s1_meta;
  logic                    room;

  // A transfer is taken only while the result queue has a free place for it after
  // counting the result still waiting on the memory read.
  assign in_fire  = in_valid && in_ready;
  assign in_ready = room;

  dq_front #(
    .CAPACITY     (CAPACITY),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .command   (command),
    .task_in   (task_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .s1_valid  (s1_valid),
    .s1_meta   (s1_meta)
  );

  // A push writes in the cycle of its transfer, so a pop in the next cycle reads the
  // new handle from the memory without any bypass.
  dq_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The back joins the read handle with the outcome and queues the finished result,
  // which lets the command side keep moving while the result side stalls.
  dq_back #(
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_meta   (s1_meta),
    .rd_data   (ram_rdata),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .task_out  (task_out),
    .got_task  (got_task),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty)
  );

endmodule

>>> src/dq_ram.sv
module dq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/dq_front.sv
module dq_front #(
  parameter int CAPACITY = 1024,
  parameter int HANDLE_WIDTH = 64,
  localparam int PTR_W = $clog2(CAPACITY) + 1,
  localparam int SLOT_W = $clog2(CAPACITY)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic [1:0]              command,
  input  logic [dq_pkg::TASK_W-1:0] task_in,
  output logic                    ram_we,
  output logic [SLOT_W-1:0]       ram_waddr,
  output logic [HANDLE_WIDTH-1:0] ram_wdata,
  output logic                    ram_re,
  output logic [SLOT_W-1:0]       ram_raddr,
  output logic                    s1_valid,
  output dq_pkg::meta_t           s1_meta
);

  import dq_pkg::*;

  localparam logic [PTR_W-1:0] CAP_P  = PTR_W'(CAPACITY);
  localparam logic [PTR_W-1:0] LAST_P = PTR_W'(2 * CAPACITY - 1);

  logic [PTR_W-1:0] top_ptr, top_ptr_next;
  logic [PTR_W-1:0] bot_ptr, bot_ptr_next;
  logic [PTR_W-1:0] cnt, cnt_next;
  logic [PTR_W-1:0] bot_inc, bot_dec, top_inc;
  logic             full, empty;
  logic             do_push, do_pop, do_steal;
  cmd_t             op;
  meta_t            meta_next;

  // Pointers run modulo twice the capacity; the slot is the pointer folded once.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= CAP_P) ? p - CAP_P : p;
    return s[SLOT_W-1:0];
  endfunction

  always_comb begin
    op       = cmd_t'(command);
    full     = (cnt == CAP_P);
    empty    = (cnt == '0);
    do_push  = in_fire && (op == CMD_PUSH) && !full;
    do_pop   = in_fire && (op == CMD_POP) && !empty;
    do_steal = in_fire && (op == CMD_STEAL) && !empty;

    bot_inc = (bot_ptr == LAST_P) ? '0 : bot_ptr + PTR_W'(1);
    bot_dec = (bot_ptr == '0) ? LAST_P : bot_ptr - PTR_W'(1);
    top_inc = (top_ptr == LAST_P) ? '0 : top_ptr + PTR_W'(1);

    bot_ptr_next = bot_ptr;
    top_ptr_next = top_ptr;
    cnt_next     = cnt;
    if (do_push) begin
      bot_ptr_next = bot_inc;
      cnt_next     = cnt + PTR_W'(1);
    end
    if (do_pop) begin
      bot_ptr_next = bot_dec;
      cnt_next     = cnt - PTR_W'(1);
    end
    if (do_steal) begin
      top_ptr_next = top_inc;
      cnt_next     = cnt - PTR_W'(1);
    end
  end

  always_comb begin
    meta_next.got = do_pop || do_steal;
    if (in_fire && (op == CMD_PUSH) && full) begin
      meta_next.status = ST_FULL;
    end else if (in_fire && ((op == CMD_POP) || (op == CMD_STEAL)) && empty) begin
      meta_next.status = ST_EMPTY;
    end else begin
      meta_next.status = ST_OK;
    end
    meta_next.count    = COUNT_W'(cnt_next);
    meta_next.is_empty = (cnt_next == '0);
  end

  always_comb begin
    ram_we    = do_push;
    ram_waddr = slot_of(bot_ptr);
    ram_wdata = task_in[HANDLE_WIDTH-1:0];
    ram_re    = do_pop || do_steal;
    ram_raddr = do_pop ? slot_of(bot_dec) : slot_of(top_ptr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_ptr  <= '0;
      bot_ptr  <= '0;
      cnt      <= '0;
      s1_valid <= 1'b0;
    end else begin
      top_ptr  <= top_ptr_next;
      bot_ptr  <= bot_ptr_next;
      cnt      <= cnt_next;
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_meta <= meta_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_P)
    else $error("item count exceeds capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (op == CMD_PUSH) && !full) |=> (cnt == $past(cnt) + PTR_W'(1)))
    else $error("accepted push did not grow the count");

  a_got_ok: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_meta.got) |-> (s1_meta.status == ST_OK))
    else $error("removed handle reported with a failing status");

endmodule

>>> src/dq_back.sv
module dq_back #(
  parameter int HANDLE_WIDTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s1_valid,
  input  dq_pkg::meta_t             s1_meta,
  input  logic [HANDLE_WIDTH-1:0]   rd_data,
  output logic                      room,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dq_pkg::TASK_W-1:0] task_out,
  output logic                      got_task,
  output logic [1:0]                status,
  output logic [dq_pkg::COUNT_W-1:0] count,
  output logic                      is_empty
);

  import dq_pkg::*;

  meta_t                   q_meta [Q_DEPTH];
  logic [HANDLE_WIDTH-1:0] q_data [Q_DEPTH];
  logic [Q_IDX_W-1:0]      wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]      q_cnt;
  logic                    q_push, q_pop;
  meta_t                   head;

  always_comb begin
    q_push    = s1_valid;
    out_valid = (q_cnt != '0);
    q_pop     = out_valid && out_ready;
    // Leave a place for the item that the front holds in its register stage.
    room      = ({1'b0, q_cnt} + {{Q_CNT_W{1'b0}}, s1_valid}) < (Q_CNT_W + 1)'(Q_DEPTH);
    head      = q_meta[rd_ptr];
    task_out  = head.got ? TASK_W'(q_data[rd_ptr]) : '0;
    got_task  = head.got;
    status    = head.status;
    count     = head.count;
    is_empty  = head.is_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + Q_IDX_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + Q_IDX_W'(1);
      end
      case ({q_push, q_pop})
        2'b10:   q_cnt <= q_cnt + Q_CNT_W'(1);
        2'b01:   q_cnt <= q_cnt - Q_CNT_W'(1);
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_meta[wr_ptr] <= s1_meta;
      q_data[wr_ptr] <= rd_data;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue over its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && (q_cnt == Q_CNT_W'(Q_DEPTH))))
    else $error("result arrived at a full queue");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == q_cnt[Q_IDX_W-1:0])
    else $error("queue pointers disagree with the fill count");

endmodule

>>> sim/testbench.sv
// Self-checking bench for the work-stealing deque.
//
// An initial block plans the whole command stream up front and leaves it in a
// queue. A clocked driver offers those commands in bursts with idle gaps in
// between. A clocked monitor sees every command transfer, runs it through a
// local model of the deque, and compares every result transfer with the oldest
// prediction still waiting. The result side stalls on a pattern of its own and
// is held off twice for a long stretch so that the internal result queue fills
// and the command side has to wait.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int DEPTH    = 1024;
  localparam int SLOT_W   = 10;
  localparam int PTR_W    = 11;
  localparam int HANDLE_W = 64;

  // One planned command and one predicted result.
  typedef struct {
    cmd_t              op;
    logic [TASK_W-1:0] handle;
  } deque_cmd_t;

  typedef struct {
    logic [TASK_W-1:0]  handle;
    logic               got;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } deque_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          command = CMD_NOP;
  logic [TASK_W-1:0]   task_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [TASK_W-1:0]   task_out;
  logic                got_task;
  logic [1:0]          status;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;

  work_stealing_deque #(
    .CAPACITY(DEPTH),
    .HANDLE_WIDTH(HANDLE_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .task_in(task_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .task_out(task_out),
    .got_task(got_task),
    .status(status),
    .count(count),
    .is_empty(is_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Commands waiting to be offered, and results waiting to come back.
  deque_cmd_t    pending_cmds[$];
  deque_result_t awaited_results[$];

  // Local model of the deque. Both pointers count modulo twice the depth, so
  // their difference is the occupancy and a full deque is told apart from an
  // empty one. The low bits of a pointer select the slot.
  logic [TASK_W-1:0] slot_copy[DEPTH];
  logic [PTR_W-1:0]  top_ptr = '0;
  logic [PTR_W-1:0]  bottom_ptr = '0;

  int errors = 0;
  int n_push = 0, n_pop = 0, n_steal = 0, n_idle = 0;
  int n_full = 0, n_empty = 0, n_taken = 0, peak_level = 0;

  // Occupancy as the stimulus planner expects it, used to steer the phases.
  int plan_level = 0;

  // Applies one command to the local model and returns the result it yields.
  function automatic deque_result_t deque_apply(cmd_t op, logic [TASK_W-1:0] handle);
    deque_result_t    res;
    logic [PTR_W-1:0] level;
    res.handle   = '0;
    res.got      = 1'b0;
    res.status   = ST_OK;
    level        = bottom_ptr - top_ptr;
    case (op)
      CMD_PUSH: begin
        if (level == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot_copy[bottom_ptr[SLOT_W-1:0]] = handle;
          bottom_ptr = bottom_ptr + 1'b1;
        end
      end
      CMD_POP: begin
        if (level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          bottom_ptr = bottom_ptr - 1'b1;
          res.handle = slot_copy[bottom_ptr[SLOT_W-1:0]];
          res.got    = 1'b1;
        end
      end
      CMD_STEAL: begin
        if (level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.handle = slot_copy[top_ptr[SLOT_W-1:0]];
          top_ptr    = top_ptr + 1'b1;
          res.got    = 1'b1;
        end
      end
      default: begin
        // The unused code leaves the contents alone and just reports them.
      end
    endcase
    level        = bottom_ptr - top_ptr;
    res.count    = level;
    res.is_empty = (level == 0);
    return res;
  endfunction

  // Handles lean toward the corners of the 64-bit range now and then.
  function automatic logic [TASK_W-1:0] pick_handle();
    logic [TASK_W-1:0] h;
    case ($urandom_range(0, 9))
      0: h = '0;
      1: h = '1;
      2: h = 64'd1 << $urandom_range(0, 63);
      3: h = ~(64'd1 << $urandom_range(0, 63));
      default: h = {$urandom, $urandom};
    endcase
    return h;
  endfunction

  task automatic plan_cmd(cmd_t op, logic [TASK_W-1:0] handle);
    deque_cmd_t c;
    c.op     = op;
    c.handle = handle;
    pending_cmds.push_back(c);
    case (op)
      CMD_PUSH:  if (plan_level < DEPTH) plan_level++;
      CMD_POP,
      CMD_STEAL: if (plan_level > 0) plan_level--;
      default:   ;
    endcase
  endtask

  // Draws a command from a mix given as cumulative percentages.
  task automatic plan_mix(int push_pct, int steal_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      plan_cmd(CMD_PUSH, pick_handle());
    else if (r < steal_pct)
      plan_cmd(CMD_STEAL, pick_handle());
    else if (r < pop_pct)
      plan_cmd(CMD_POP, pick_handle());
    else
      plan_cmd(CMD_NOP, pick_handle());
  endtask

  // Driver: a new command goes out only when the bus is free or the current
  // one transfers at this edge, so valid and the payload hold until then.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    deque_cmd_t c;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= $urandom_range(1, 40);
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        command  <= c.op;
        task_in  <= c.handle;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          // End of a burst: sometimes run straight on, mostly pause a little.
          burst_left <= $urandom_range(1, 60);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long hold-offs of the result side, counted in cycles after reset. The
  // sender is still busy at both points, so the result queue inside the block
  // fills and in_ready has to drop.
  int   cycle_no = 0;
  logic long_hold = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      cycle_no  <= 0;
      long_hold <= 1'b0;
    end else begin
      cycle_no  <= cycle_no + 1;
      long_hold <= (cycle_no >= 700 && cycle_no < 820) ||
                   (cycle_no >= 1800 && cycle_no < 1900);
    end
  end

  // Receiver: switches between always ready, coin-flip ready and mostly
  // stalled, staying in each mode for a random stretch.
  int ready_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(10, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       out_ready <= !long_hold;
        1:       out_ready <= !long_hold && ($urandom_range(0, 1) == 1);
        default: out_ready <= !long_hold && ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Monitor: the command transfer is modeled first, so that a prediction is
  // in place before any result of the same edge is checked.
  always @(posedge clk) begin
    deque_result_t pred;
    deque_result_t want;
    if (!rst && in_valid && in_ready) begin
      pred = deque_apply(cmd_t'(command), task_in);
      awaited_results.push_back(pred);
      case (cmd_t'(command))
        CMD_PUSH:  n_push++;
        CMD_POP:   n_pop++;
        CMD_STEAL: n_steal++;
        default:   n_idle++;
      endcase
      if (pred.status == ST_FULL) n_full++;
      if (pred.status == ST_EMPTY) n_empty++;
      if (pred.got) n_taken++;
      if (pred.count > peak_level) peak_level = pred.count;
    end
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (task_out !== want.handle) begin
          $error("task_out: expected %h, got %h", want.handle, task_out);
          errors++;
        end
        if (got_task !== want.got) begin
          $error("got_task: expected %0d, got %0d", want.got, got_task);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          errors++;
        end
        if (is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [TASK_W-1:0] h;

    // Directed opening: removals and the unused code on an empty deque, the
    // corner handles, LIFO order at the bottom against FIFO order at the top,
    // and commands around a push that carry a handle field they ignore.
    plan_cmd(CMD_STEAL, pick_handle());
    plan_cmd(CMD_POP, '1);
    plan_cmd(CMD_NOP, '1);
    plan_cmd(CMD_PUSH, '0);
    plan_cmd(CMD_PUSH, '1);
    plan_cmd(CMD_PUSH, 64'h8000_0000_0000_0000);
    plan_cmd(CMD_PUSH, 64'h0000_0000_0000_0001);
    h = {$urandom, $urandom};
    plan_cmd(CMD_PUSH, h);
    plan_cmd(CMD_NOP, ~h);
    plan_cmd(CMD_POP, ~h);
    plan_cmd(CMD_STEAL, h);
    plan_cmd(CMD_STEAL, '0);
    plan_cmd(CMD_POP, '1);
    plan_cmd(CMD_POP, '0);
    // Removals from both ends of the deque, which is empty again.
    plan_cmd(CMD_POP, '1);
    plan_cmd(CMD_POP, '1);
    plan_cmd(CMD_STEAL, '1);
    plan_cmd(CMD_PUSH, 64'h5555_5555_5555_5555);
    plan_cmd(CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
    plan_cmd(CMD_STEAL, '0);
    plan_cmd(CMD_STEAL, '0);
    plan_cmd(CMD_STEAL, '0);

    // Streaming phase: mostly pushes and steals, which keep both pointers moving forward.
    repeat (100) plan_mix(50, 75, 95);

    // Fill to capacity, then knock on the full deque and refill its top slot.
    while (plan_level < DEPTH) plan_mix(95, 97, 99);
    repeat (4) plan_cmd(CMD_PUSH, pick_handle());
    plan_cmd(CMD_NOP, pick_handle());
    plan_cmd(CMD_POP, pick_handle());
    plan_cmd(CMD_PUSH, pick_handle());
    plan_cmd(CMD_PUSH, pick_handle());
    plan_cmd(CMD_STEAL, pick_handle());
    plan_cmd(CMD_PUSH, pick_handle());
    plan_cmd(CMD_PUSH, pick_handle());

    // Drain part of the way, mostly from the top.
    repeat (400) plan_mix(5, 65, 95);

    // Tail: a balanced mix on the partly drained deque.
    repeat (150) plan_mix(45, 70, 93);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    // Give stray results a chance to show up.
    repeat (10) @(posedge clk);

    $display("Ran %0d pushes, %0d pops, %0d steals and %0d unused-code commands.",
             n_push, n_pop, n_steal, n_idle);
    $display("%0d handles taken, %0d full and %0d empty rejections, peak occupancy %0d.",
             n_taken, n_full, n_empty, peak_level);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond a correct run even with every stall at its worst.
  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> work_stealing_deque.f
src/dq_pkg.sv
src/dq_ram.sv
src/dq_front.sv
src/dq_back.sv
src/work_stealing_deque.sv
sim/testbench.sv
